>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL; they compile away when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// prop must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// cond must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

>>> rtl/u16u32dec_pkg.sv
// ----------------------------------------------------------------------------
// u16u32dec_pkg
// Beat types, job format and codes for the UTF-16 to UTF-32 byte decoder.
// ----------------------------------------------------------------------------
package u16u32dec_pkg;

  localparam int CP_W = 21;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_stream;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [2:0] error_code;
    logic       last_of_run;
  } out_beat_t;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_NO_BOM    = 3'd1;
  localparam logic [2:0] ERR_TRUNC     = 3'd2;
  localparam logic [2:0] ERR_BAD_TRAIL = 3'd3;
  localparam logic [2:0] ERR_NONCHAR   = 3'd4;
  localparam logic [2:0] ERR_STRAY     = 3'd5;

  // One job per result run: either a code point to serialize or an error.
  typedef struct packed {
    logic              is_err;
    logic [2:0]        err;
    logic              big_endian;
    logic [CP_W-1:0]   cp;
  } job_t;

  typedef enum logic [2:0] {
    PH_BOM0,
    PH_BOM1,
    PH_U0,
    PH_U1,
    PH_T0,
    PH_T1
  } phase_t;

  localparam logic [CP_W-1:0] BOM_CP    = 21'h00FEFF;
  localparam logic [CP_W-1:0] PLANE1_CP = 21'h010000;

endpackage

>>> rtl/utf16_to_utf32_byte_decoder_top.sv
// ----------------------------------------------------------------------------
// utf16_to_utf32_byte_decoder_top
// UTF-16 byte stream in, UTF-32 byte stream out, BOM-driven byte order.
// ----------------------------------------------------------------------------
// Input channel: one UTF-16 byte per beat (in_push / in_full), BOM first,
// end_of_stream marking the final byte of a stream. Result channel: queue
// style (out_empty / out_pop); each beat carries one UTF-32 byte, an error
// code and last_of_run on the final beat of a run.
// A valid BOM produces a 4-byte UTF-32 BOM; each completed code point
// produces 4 bytes in the detected byte order. Any error produces one beat
// with error_code set and then halts: further bytes are taken and dropped.
// With the serializer idle, a run's first beat reaches out_data once its job
// has been written into the job queue and then loaded into the serializer.
// Throughput: the output serializer sends one beat per cycle while out_pop is
// high, so a 2-byte BMP unit yields 4 output beats. The front end and
// serializer are split by a 2-entry job queue.
// When the receiver stalls, the queue fills and in_full rises; bytes that
// produce no result are still blocked only while the queue is full.
// Reset (rst_n low, synchronous) clears the phase, byte order, halt flag
// and all queued work; the next byte is expected to be a BOM byte.
// ----------------------------------------------------------------------------
module utf16_to_utf32_byte_decoder_top (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_push,
  output logic                     in_full,
  input  u16u32dec_pkg::in_beat_t  in_data,
  output logic                     out_empty,
  input  logic                     out_pop,
  output u16u32dec_pkg::out_beat_t out_data
);
  import u16u32dec_pkg::*;

  logic q_push, q_full, q_pop, q_valid;
  job_t q_job, q_head;

  u16u32dec_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_data (in_data),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_job   (q_job)
  );

  u16u32dec_jobq u_jobq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_job),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (q_head)
  );

  u16u32dec_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

>>> rtl/u16u32dec_front.sv
// ----------------------------------------------------------------------------
// u16u32dec_front
// Accepts UTF-16 bytes, tracks BOM / unit / surrogate phase, emits jobs.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module u16u32dec_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_push,
  output logic                    in_full,
  input  u16u32dec_pkg::in_beat_t in_data,
  input  logic                    q_full,
  output logic                    q_push,
  output u16u32dec_pkg::job_t     q_job
);
  import u16u32dec_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic        be_r, be_nxt;
  logic [7:0]  held_r, held_nxt;
  logic [9:0]  lead_r, lead_nxt;
  logic        halted_r, halted_nxt;

  logic            accept;
  logic            emit;
  job_t            job;
  logic [15:0]     unit;
  logic [CP_W-1:0] pair_cp;
  logic [7:0]      b;
  logic            eos;

  function automatic logic is_bmp_nonchar(input logic [15:0] u);
    is_bmp_nonchar = (u[15:1] == 15'h7FFF) || ((u >= 16'hFDD0) && (u <= 16'hFDEF));
  endfunction

  assign b       = in_data.in_byte;
  assign eos     = in_data.end_of_stream;
  assign in_full = q_full;
  assign accept  = in_push & ~q_full;
  assign unit    = be_r ? {held_r, b} : {b, held_r};
  assign pair_cp = PLANE1_CP + {1'b0, lead_r, unit[9:0]};

  always_comb begin
    phase_nxt      = phase_r;
    be_nxt         = be_r;
    held_nxt       = held_r;
    lead_nxt       = lead_r;
    halted_nxt     = halted_r;
    emit           = 1'b0;
    job            = '0;
    job.big_endian = be_r;
    if (!halted_r) begin
      unique case (phase_r)
        PH_BOM0: begin
          if (eos) begin
            emit = 1'b1; job.is_err = 1'b1; job.err = ERR_NO_BOM;
          end else begin
            held_nxt  = b;
            phase_nxt = PH_BOM1;
          end
        end
        PH_BOM1: begin
          if ((held_r == 8'hFE && b == 8'hFF) || (held_r == 8'hFF && b == 8'hFE)) begin
            be_nxt         = (held_r == 8'hFE);
            emit           = 1'b1;
            job.cp         = BOM_CP;
            job.big_endian = be_nxt;
            phase_nxt      = eos ? PH_BOM0 : PH_U0;
          end else begin
            emit = 1'b1; job.is_err = 1'b1; job.err = ERR_NO_BOM;
          end
        end
        PH_U0, PH_T0: begin
          if (eos) begin
            emit = 1'b1; job.is_err = 1'b1; job.err = ERR_TRUNC;
          end else begin
            held_nxt  = b;
            phase_nxt = (phase_r == PH_U0) ? PH_U1 : PH_T1;
          end
        end
        PH_U1: begin
          if (unit[15:10] == 6'b110111) begin
            emit = 1'b1; job.is_err = 1'b1; job.err = ERR_STRAY;
          end else if (unit[15:10] == 6'b110110) begin
            if (eos) begin
              emit = 1'b1; job.is_err = 1'b1; job.err = ERR_TRUNC;
            end else begin
              lead_nxt  = unit[9:0];
              phase_nxt = PH_T0;
            end
          end else if (is_bmp_nonchar(unit)) begin
            emit = 1'b1; job.is_err = 1'b1; job.err = ERR_NONCHAR;
          end else begin
            emit      = 1'b1;
            job.cp    = {5'd0, unit};
            phase_nxt = eos ? PH_BOM0 : PH_U0;
          end
        end
        PH_T1: begin
          if (unit[15:10] != 6'b110111) begin
            emit = 1'b1; job.is_err = 1'b1; job.err = ERR_BAD_TRAIL;
          end else if (pair_cp[15:1] == 15'h7FFF) begin
            emit = 1'b1; job.is_err = 1'b1; job.err = ERR_NONCHAR;
          end else begin
            emit      = 1'b1;
            job.cp    = pair_cp;
            phase_nxt = eos ? PH_BOM0 : PH_U0;
          end
        end
        default: phase_nxt = PH_BOM0;
      endcase
      if (job.is_err) halted_nxt = 1'b1;
    end
  end

  assign q_push = accept & emit;
  assign q_job  = job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_BOM0;
      be_r     <= 1'b0;
      held_r   <= '0;
      lead_r   <= '0;
      halted_r <= 1'b0;
    end else if (accept) begin
      phase_r  <= phase_nxt;
      be_r     <= be_nxt;
      held_r   <= held_nxt;
      lead_r   <= lead_nxt;
      halted_r <= halted_nxt;
    end
  end

  `ASSERT_CLK(a_halt_sticks, clk, rst_n, halted_r |=> halted_r, "halt released without reset")
  `ASSERT_CLK(a_err_halts, clk, rst_n, (q_push && q_job.is_err) |=> halted_r,
              "error job did not halt the front")
  `ASSERT_NEVER(a_no_job_halted, clk, rst_n, q_push && halted_r, "job issued while halted")

endmodule

>>> rtl/u16u32dec_jobq.sv
// ----------------------------------------------------------------------------
// u16u32dec_jobq
// Two-entry job queue between the byte front end and the serializer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module u16u32dec_jobq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  u16u32dec_pkg::job_t push_job,
  output logic                full,
  input  logic                pop,
  output logic                valid,
  output u16u32dec_pkg::job_t head
);
  import u16u32dec_pkg::*;

  localparam int DEPTH = 2;

  job_t       slot_r [DEPTH];
  logic       wr_r, wr_nxt;
  logic       rd_r, rd_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign full    = (cnt_r == 2'(DEPTH));
  assign valid   = (cnt_r != 2'd0);
  assign head    = slot_r[rd_r];
  assign do_push = push & ~full;
  assign do_pop  = pop & valid;

  always_comb begin
    wr_nxt  = do_push ? ~wr_r : wr_r;
    rd_nxt  = do_pop ? ~rd_r : rd_r;
    cnt_nxt = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_r] <= push_job;
  end

  `ASSERT_NEVER(a_push_when_full, clk, rst_n, push && full, "job pushed into a full queue")
  `ASSERT_CLK(a_ptr_match, clk, rst_n, (cnt_r == 2'd0 || cnt_r == 2'd2) |-> (wr_r == rd_r),
              "pointers disagree with count")

endmodule

>>> rtl/u16u32dec_back.sv
// ----------------------------------------------------------------------------
// u16u32dec_back
// Serializes jobs into output beats: four code point bytes or one error.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module u16u32dec_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     q_valid,
  input  u16u32dec_pkg::job_t      q_head,
  output logic                     q_pop,
  output logic                     out_empty,
  input  logic                     out_pop,
  output u16u32dec_pkg::out_beat_t out_data
);
  import u16u32dec_pkg::*;

  logic       busy_r, busy_nxt;
  job_t       job_r, job_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       last_beat;
  logic       take;
  logic [1:0] sel;
  logic [31:0] word;

  assign last_beat = job_r.is_err || (idx_r == 2'd3);
  // load a new job when idle or when the final beat of this one leaves
  assign take      = ~busy_r | (out_pop & last_beat);
  assign q_pop     = take & q_valid;

  always_comb begin
    busy_nxt = busy_r;
    job_nxt  = job_r;
    idx_nxt  = idx_r;
    if (take) begin
      busy_nxt = q_valid;
      job_nxt  = q_head;
      idx_nxt  = 2'd0;
    end else if (out_pop) begin
      idx_nxt = idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 2'd0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
  end

  assign word = {{(32-CP_W){1'b0}}, job_r.cp};
  assign sel  = job_r.big_endian ? (2'd3 - idx_r) : idx_r;

  always_comb begin
    out_data = '0;
    if (!job_r.is_err) begin
      unique case (sel)
        2'd0: out_data.out_byte = word[7:0];
        2'd1: out_data.out_byte = word[15:8];
        2'd2: out_data.out_byte = word[23:16];
        2'd3: out_data.out_byte = word[31:24];
      endcase
      out_data.error_code = ERR_NONE;
    end else begin
      out_data.error_code = job_r.err;
    end
    out_data.last_of_run = last_beat;
  end

  assign out_empty = ~busy_r;

  `ASSERT_CLK(a_err_is_last, clk, rst_n,
              (!out_empty && out_data.error_code != ERR_NONE) |-> out_data.last_of_run,
              "error beat not marked last")
  `ASSERT_CLK(a_idx_moves, clk, rst_n,
              (busy_r && !out_pop) |=> $stable(idx_r), "byte index moved while stalled")

endmodule

>>> sim/utf16_to_utf32_byte_decoder_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf16_to_utf32_byte_decoder_top_test
// Self-checking bench for the UTF-16 to UTF-32 byte decoder. Well-formed
// UTF-16 streams with random byte order and code points go in; each output
// beat is checked against a local decoder model. Since any error halts the
// block until reset, the run closes with one randomly chosen error case.
// ----------------------------------------------------------------------------
module utf16_to_utf32_byte_decoder_top_test;
  import u16u32dec_pkg::*;

  localparam int STREAM_BYTES = 410;
  localparam int MAX_REPORTS  = 20;

  logic      clk;
  logic      rst_n;
  logic      in_push;
  logic      in_full;
  in_beat_t  in_data;
  logic      out_empty;
  logic      out_pop;
  out_beat_t out_data;

  utf16_to_utf32_byte_decoder_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

  in_beat_t  pending_bytes[$];
  out_beat_t expected_out[$];

  // decoder model state
  phase_t      dec_phase;
  logic        dec_big_endian;
  logic [7:0]  dec_held;
  logic [9:0]  dec_lead;
  logic        dec_halted;

  int  mismatches;
  int  bytes_taken;
  int  beats_checked;
  int  stream_count;
  int  closing_err;
  int  dropped_bytes;
  bit  in_taken;
  int  burst_left;
  int  gap_left;
  int  cyc;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- model
  function automatic bit is_nonchar(int cp);
    if ((cp & 'hFFFF) == 'hFFFE || (cp & 'hFFFF) == 'hFFFF) return 1'b1;
    return cp >= 'hFDD0 && cp <= 'hFDEF;
  endfunction

  function automatic logic [15:0] join_unit(logic [7:0] first, logic [7:0] second);
    return dec_big_endian ? {first, second} : {second, first};
  endfunction

  function void expect_error(logic [2:0] code);
    out_beat_t r;
    r.out_byte    = 8'h00;
    r.error_code  = code;
    r.last_of_run = 1'b1;
    expected_out.push_back(r);
    dec_halted = 1'b1;
  endfunction

  function void expect_word(int w);
    out_beat_t r;
    int        sh;
    for (int k = 0; k < 4; k++) begin
      sh            = dec_big_endian ? 24 - 8 * k : 8 * k;
      r.out_byte    = 8'((w >> sh) & 'hFF);
      r.error_code  = ERR_NONE;
      r.last_of_run = (k == 3);
      expected_out.push_back(r);
    end
  endfunction

  function void decode_byte(in_beat_t b);
    logic [15:0] unit;
    int          cp;
    if (dec_halted) begin
      dropped_bytes++;
      return;
    end
    case (dec_phase)
      PH_BOM0: begin
        if (b.end_of_stream) begin
          expect_error(ERR_NO_BOM);
        end else begin
          dec_held  = b.in_byte;
          dec_phase = PH_BOM1;
        end
      end
      PH_BOM1: begin
        if (dec_held == 8'hFE && b.in_byte == 8'hFF) begin
          dec_big_endian = 1'b1;
        end else if (dec_held == 8'hFF && b.in_byte == 8'hFE) begin
          dec_big_endian = 1'b0;
        end else begin
          expect_error(ERR_NO_BOM);
          return;
        end
        dec_phase = b.end_of_stream ? PH_BOM0 : PH_U0;
        expect_word('hFEFF);
      end
      PH_U0, PH_T0: begin
        if (b.end_of_stream) begin
          expect_error(ERR_TRUNC);
        end else begin
          dec_held  = b.in_byte;
          dec_phase = (dec_phase == PH_U0) ? PH_U1 : PH_T1;
        end
      end
      PH_U1: begin
        unit = join_unit(dec_held, b.in_byte);
        // stray trail wins over truncation
        if (unit >= 16'hDC00 && unit <= 16'hDFFF) begin
          expect_error(ERR_STRAY);
        end else if (unit >= 16'hD800 && unit <= 16'hDBFF) begin
          if (b.end_of_stream) begin
            expect_error(ERR_TRUNC);
          end else begin
            dec_lead  = unit[9:0];
            dec_phase = PH_T0;
          end
        end else if (is_nonchar(int'(unit))) begin
          expect_error(ERR_NONCHAR);
        end else begin
          dec_phase = b.end_of_stream ? PH_BOM0 : PH_U0;
          expect_word(int'(unit));
        end
      end
      PH_T1: begin
        unit = join_unit(dec_held, b.in_byte);
        if (unit < 16'hDC00 || unit > 16'hDFFF) begin
          expect_error(ERR_BAD_TRAIL);
        end else begin
          cp = (int'(dec_lead) << 10) + int'(unit[9:0]) + 'h10000;
          if (is_nonchar(cp)) begin
            expect_error(ERR_NONCHAR);
          end else begin
            dec_phase = b.end_of_stream ? PH_BOM0 : PH_U0;
            expect_word(cp);
          end
        end
      end
      default: dec_phase = PH_BOM0;
    endcase
  endfunction

  // ------------------------------------------------------------- stimulus
  function void add_byte(logic [7:0] v, logic eos);
    in_beat_t b;
    b.in_byte       = v;
    b.end_of_stream = eos;
    pending_bytes.push_back(b);
  endfunction

  function void add_unit(logic [15:0] u, bit be, logic eos);
    if (be) begin
      add_byte(u[15:8], 1'b0);
      add_byte(u[7:0], eos);
    end else begin
      add_byte(u[7:0], 1'b0);
      add_byte(u[15:8], eos);
    end
  endfunction

  function void add_bom(bit be, logic eos);
    add_unit(16'hFEFF, be, eos);
    stream_count++;
  endfunction

  function void add_cp(int cp, bit be, logic eos);
    int v;
    if (cp < 'h10000) begin
      add_unit(16'(cp), be, eos);
    end else begin
      v = cp - 'h10000;
      add_unit(16'hD800 | 16'(v >> 10), be, 1'b0);
      add_unit(16'hDC00 | 16'(v & 'h3FF), be, eos);
    end
  endfunction

  function automatic int pick_bmp();
    int u;
    do begin
      case ($urandom_range(0, 5))
        0: u = $urandom_range(0, 'h7F);
        1: u = $urandom_range('hD700, 'hD7FF);
        2: u = $urandom_range('hE000, 'hE0FF);
        3: u = $urandom_range('hFDC0, 'hFDFF);
        4: u = $urandom_range('hFF00, 'hFFFF);
        default: u = $urandom_range(0, 'hFFFF);
      endcase
    end while ((u >= 'hD800 && u <= 'hDFFF) || is_nonchar(u));
    return u;
  endfunction

  function automatic int pick_supp();
    int low;
    low = ($urandom_range(0, 3) == 0) ? $urandom_range('hFDD0, 'hFDEF)
                                      : $urandom_range(0, 'hFFFD);
    return ($urandom_range(1, 16) << 16) | low;
  endfunction

  function void add_stream();
    bit be;
    int n;
    be = $urandom_range(0, 1);
    n  = $urandom_range(0, 8);
    add_bom(be, n == 0);
    for (int i = 0; i < n; i++)
      add_cp(($urandom_range(0, 9) < 7) ? pick_bmp() : pick_supp(), be, i == n - 1);
  endfunction

  // Any broken sequence halts the block for good, so exactly one error
  // case closes the run, followed by bytes that must be dropped silently.
  function void add_error_tail();
    bit be;
    be          = $urandom_range(0, 1);
    closing_err = $urandom_range(int'(ERR_NO_BOM), int'(ERR_STRAY));
    case (closing_err)
      int'(ERR_NO_BOM): begin
        if ($urandom_range(0, 1)) begin
          add_byte(8'($urandom), 1'b1);
        end else begin
          add_byte(8'hFE, 1'b0);
          add_byte(8'($urandom_range(0, 1) ? 8'hFE : 8'($urandom_range(0, 'hFE))), 1'b0);
        end
      end
      int'(ERR_TRUNC): begin
        add_bom(be, 1'b0);
        case ($urandom_range(0, 2))
          0: add_byte(8'($urandom), 1'b1);
          1: add_unit(16'($urandom_range('hD800, 'hDBFF)), be, 1'b1);
          default: begin
            add_unit(16'($urandom_range('hD800, 'hDBFF)), be, 1'b0);
            add_byte(8'($urandom), 1'b1);
          end
        endcase
      end
      int'(ERR_BAD_TRAIL): begin
        add_bom(be, 1'b0);
        add_unit(16'($urandom_range('hD800, 'hDBFF)), be, 1'b0);
        add_unit(16'($urandom_range(0, 1) ? $urandom_range('hD800, 'hDBFF) : pick_bmp()),
                 be, 1'($urandom_range(0, 1)));
      end
      int'(ERR_NONCHAR): begin
        add_bom(be, 1'b0);
        case ($urandom_range(0, 2))
          0: add_unit(16'($urandom_range('hFDD0, 'hFDEF)), be, 1'b0);
          1: add_unit(16'($urandom_range('hFFFE, 'hFFFF)), be, 1'b0);
          default: add_cp(($urandom_range(1, 16) << 16) | $urandom_range('hFFFE, 'hFFFF),
                          be, 1'b0);
        endcase
      end
      default: begin
        add_bom(be, 1'b0);
        add_unit(16'($urandom_range('hDC00, 'hDFFF)), be, 1'($urandom_range(0, 1)));
      end
    endcase
    for (int i = 0; i < 6; i++)
      add_byte(8'($urandom), 1'($urandom_range(0, 1)));
  endfunction

  // --------------------------------------------------------------- driver
  always @(negedge clk) begin
    logic nxt_push;
    nxt_push = 1'b0;
    if (!rst_n) begin
      in_push <= 1'b0;
      out_pop <= 1'b0;
    end else begin
      if (in_taken) begin
        void'(pending_bytes.pop_front());
        in_taken = 1'b0;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
        end
      end
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_bytes.size() > 0) begin
        nxt_push = 1'b1;
        in_data <= pending_bytes[0];
      end
      in_push <= nxt_push;

      cyc++;
      case ((cyc >> 6) % 4)
        0: out_pop <= 1'b1;
        1: out_pop <= 1'($urandom_range(0, 1));
        2: out_pop <= (cyc % 7) < 2;
        default: out_pop <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // -------------------------------------------------------------- monitor
  always @(posedge clk) begin
    out_beat_t want;
    if (rst_n) begin
      if (in_push && !in_full) begin
        decode_byte(in_data);
        bytes_taken++;
        in_taken = 1'b1;
      end
      if (out_pop && !out_empty) begin
        beats_checked++;
        if (expected_out.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: unexpected beat byte=%h err=%0d last=%b", $time,
                     out_data.out_byte, out_data.error_code, out_data.last_of_run);
        end else begin
          want = expected_out.pop_front();
          if (out_data.out_byte !== want.out_byte ||
              out_data.error_code !== want.error_code ||
              out_data.last_of_run !== want.last_of_run) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("%0t: mismatch expected byte=%h err=%0d last=%b, got byte=%h err=%0d last=%b",
                       $time, want.out_byte, want.error_code, want.last_of_run,
                       out_data.out_byte, out_data.error_code, out_data.last_of_run);
          end
        end
      end
    end
  end

  // ----------------------------------------------------------------- main
  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_push        = 1'b0;
    in_data        = '0;
    out_pop        = 1'b0;
    dec_phase      = PH_BOM0;
    dec_big_endian = 1'b0;
    dec_held       = 8'h00;
    dec_lead       = 10'h000;
    dec_halted     = 1'b0;
    mismatches     = 0;
    bytes_taken    = 0;
    beats_checked  = 0;
    stream_count   = 0;
    dropped_bytes  = 0;
    in_taken       = 1'b0;
    burst_left     = 8;
    gap_left       = 0;
    cyc            = 0;

    // directed: both byte orders, BMP and surrogate edges, mark-only stream
    add_bom(1'b1, 1'b0);
    add_cp('h0000, 1'b1, 1'b0);
    add_cp('hD7FF, 1'b1, 1'b0);
    add_cp('hE000, 1'b1, 1'b0);
    add_cp('hFDCF, 1'b1, 1'b0);
    add_cp('h10000, 1'b1, 1'b0);
    add_cp('h10FFFD, 1'b1, 1'b1);
    add_bom(1'b0, 1'b1);
    add_bom(1'b0, 1'b0);
    add_cp('hFFFD, 1'b0, 1'b0);
    add_cp('h1FDD0, 1'b0, 1'b0);
    add_cp('hFDF0, 1'b0, 1'b1);

    while (pending_bytes.size() < STREAM_BYTES)
      add_stream();
    add_error_tail();

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (pending_bytes.size() != 0 || expected_out.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);

    if (expected_out.size() != 0) begin
      mismatches++;
      $display("%0t: %0d expected beats never arrived", $time, expected_out.size());
    end
    $display("tb: %0d bytes in %0d streams accepted, %0d output beats checked",
             bytes_taken, stream_count, beats_checked);
    $display("tb: run closed by error code %0d, %0d bytes dropped while halted",
             closing_err, dropped_bytes);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("%0t: timeout", $time);
    $display("tb: failure");
    $finish;
  end

endmodule

>>> utf16_to_utf32_byte_decoder_top.f
+incdir+rtl
rtl/u16u32dec_pkg.sv
rtl/u16u32dec_front.sv
rtl/u16u32dec_jobq.sv
rtl/u16u32dec_back.sv
rtl/utf16_to_utf32_byte_decoder_top.sv
sim/utf16_to_utf32_byte_decoder_top_test.sv
